/* src/sfm_pkg.sv */
// ----------------------------------------------------------------------------
// sfm_pkg
// shared types and constants of the substring first-match unit
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;
  localparam int unsigned TEXT_MAX_DEF    = 1024;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OPC_W  = 2;
  localparam int unsigned POS_W  = 10;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef struct packed {
    logic              valid;
    op_e               opcode;
    logic [BYTE_W-1:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             truncated;
  } res_t;

endpackage

/* src/sfm_match_core.sv */
// ----------------------------------------------------------------------------
// sfm_match_core
// pattern shift register, text window, parallel compare and match latch
// ----------------------------------------------------------------------------
module sfm_match_core import sfm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output res_t res_o
);

  localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(TEXT_MAX + 1);
  localparam int unsigned MAX_LC = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int unsigned WIDE_W = (MAX_LC > POS_W) ? MAX_LC : POS_W;

  // pattern held newest byte first, so entry j lines up with window entry j
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_q, pat_d;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_q, win_d;
  logic [LEN_W-1:0]                   plen_q, plen_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d, cnt_inc;
  logic                               hit_q, hit_d;
  logic [POS_W-1:0]                   pos_q, pos_d;
  logic                               ovf_q, ovf_d;
  logic [PATTERN_MAX-1:0]             lane_ok;
  logic                               win_match;
  logic                               pat_full;
  logic                               txt_full;
  logic [WIDE_W-1:0]                  cnt_wide;
  logic [WIDE_W-1:0]                  plen_wide;
  logic [WIDE_W-1:0]                  start_wide;
  logic                               pat_shift;
  logic                               win_shift;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
    if (j == 0) begin : g_head
      assign pat_d[j] = cmd_i.data_byte;
      assign win_d[j] = cmd_i.data_byte;
    end else begin : g_tail
      assign pat_d[j] = pat_q[j-1];
      assign win_d[j] = win_q[j-1];
    end
    assign lane_ok[j] = (win_d[j] == pat_q[j]) || !(j < int'(plen_q));
  end

  assign win_match  = &lane_ok;
  assign pat_full   = (plen_q == LEN_W'(PATTERN_MAX));
  assign txt_full   = (cnt_q == CNT_W'(TEXT_MAX));
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign cnt_wide   = WIDE_W'(cnt_inc);
  assign plen_wide  = WIDE_W'(plen_q);
  assign start_wide = cnt_wide - plen_wide;

  assign pat_shift = cmd_i.valid && (cmd_i.opcode == OP_APPEND) && !pat_full;
  assign win_shift = cmd_i.valid && (cmd_i.opcode == OP_TEXT) && !txt_full;

  always_comb begin
    plen_d = plen_q;
    cnt_d  = cnt_q;
    hit_d  = hit_q;
    pos_d  = pos_q;
    ovf_d  = ovf_q;
    res_o  = '0;
    if (cmd_i.valid) begin
      unique case (cmd_i.opcode)
        OP_CLEAR: begin
          plen_d = '0;
          cnt_d  = '0;
          hit_d  = 1'b0;
          pos_d  = '0;
          ovf_d  = 1'b0;
        end
        OP_APPEND: begin
          if (pat_full) begin
            ovf_d = 1'b1;
          end else begin
            plen_d = plen_q + LEN_W'(1);
          end
        end
        OP_TEXT: begin
          if (txt_full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_inc;
            if (!hit_q && (plen_q != '0) && (cnt_wide >= plen_wide) && win_match) begin
              hit_d = 1'b1;
              pos_d = start_wide[POS_W-1:0];
            end
          end
        end
        OP_END: begin
          res_o.valid          = 1'b1;
          res_o.found          = (plen_q == '0) || hit_q;
          res_o.match_position = (plen_q == '0) ? '0 : pos_q;
          res_o.truncated      = ovf_q;
          cnt_d                = '0;
          hit_d                = 1'b0;
          pos_d                = '0;
          ovf_d                = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      pos_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      plen_q <= plen_d;
      cnt_q  <= cnt_d;
      hit_q  <= hit_d;
      pos_q  <= pos_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_shift) begin
      pat_q <= pat_d;
    end
    if (win_shift) begin
      win_q <= win_d;
    end
  end

  a_plen_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= LEN_W'(PATTERN_MAX))
    else $error("pattern length above capacity");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TEXT_MAX))
    else $error("text count above capacity");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && (cmd_i.opcode == OP_CLEAR) |=> (plen_q == '0) && !hit_q && !ovf_q)
    else $error("clear left pattern or search state behind");

  a_miss_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.found |-> res_o.match_position == '0)
    else $error("miss reported with nonzero position");

  a_end_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (cnt_q == '0) && !hit_q && !ovf_q)
    else $error("end of text did not restart the search");

endmodule

/* src/substring_first_match_unit.sv */
// ----------------------------------------------------------------------------
// substring_first_match_unit
// first occurrence of a loaded byte pattern in a streamed text
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless the input is stalled as told below: clear
// pattern, append pattern byte, text byte or end of text, with the opcode on
// tuser and the byte on tdata. Each beat is registered, then updates the
// pattern and the text window in the next cycle, where the newest PATTERN_MAX
// text bytes are compared with the pattern in parallel in a single compare.
// An end of text beat, once it leaves the input register, loads one result
// beat into the output register, carrying found, the start of the first match
// and the truncated flag. The output register lets new beats enter while a
// result waits; only a second end of text beat stalls the input until the
// waiting result is taken.
module substring_first_match_unit import sfm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [0] found, [10:1] match_position,
                                        // [11] truncated, [15:12] zero
);

  logic              in_vld_q;
  op_e               in_op_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              advance;
  logic              load;
  cmd_t              cmd;
  res_t              res;
  logic              out_vld_q;
  res_t              out_q;

  assign advance = in_vld_q && ((in_op_q != OP_END) || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign load = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (res.valid) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_op_q   <= op_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign cmd.valid     = advance;
  assign cmd.opcode    = in_op_q;
  assign cmd.data_byte = in_byte_q;

  sfm_match_core #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .res_o (res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.truncated, out_q.match_position, out_q.found};

  a_no_result_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !out_vld_q || m_axis_tready_i)
    else $error("result produced while output register still full");

  a_result_follows_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_op_q == OP_END) |=> out_vld_q)
    else $error("end of text beat gave no result");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |-> !s_axis_tready_o)
    else $error("input taken while stage is stalled");

endmodule

/* test/substring_first_match_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match_unit_tb
// self-checking bench for the substring first-match unit
// ----------------------------------------------------------------------------
// Drives clear, append, text and end-of-text beats into the unit and keeps a
// behavioral copy of its pattern store, text window and match latch. Each end
// of text beat queues the expected found, position and truncated values, and
// every result beat is checked against the oldest one. A short table covers
// the corner cases, then overflow bursts, an output hold-off that backs up the
// input, and a few hundred random beats in pattern/text/end sessions, with
// random gaps on both sides.
// ----------------------------------------------------------------------------
module substring_first_match_unit_tb;
  import sfm_pkg::*;

  localparam int unsigned PMAX        = PATTERN_MAX_DEF;
  localparam int unsigned TMAX        = TEXT_MAX_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned RANDOM_BEATS = 250;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic             trunc;
  } verdict_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic             pinned;
    logic             want_found;
    logic [POS_W-1:0] want_pos;
    logic             want_trunc;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser_i;   // [1:0] opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [0] found, [10:1] match_position,
                                 // [11] truncated, [15:12] zero

  substring_first_match_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // predictor state
  logic [7:0]  pat_bytes [PMAX];
  int unsigned pat_len;
  logic [7:0]  text_win [PMAX];
  int unsigned text_cnt;
  logic        hit_latched;
  int unsigned hit_start;
  logic        dropped_seen;

  verdict_t    expected_verdicts [$];
  int unsigned mismatch_count;
  int unsigned verdicts_seen;
  int unsigned hits_seen;
  int unsigned beats_sent;
  int unsigned pattern_loads;
  int unsigned cycle_count;
  logic        steady;
  logic        long_hold_req;
  logic [7:0]  alpha0;
  logic [7:0]  alpha1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom);
    return (r < 5) ? alpha0 : alpha1;
  endfunction

  function automatic void drop_text_state();
    for (int unsigned k = 0; k < PMAX; k++) text_win[k] = 8'h00;
    text_cnt     = 0;
    hit_latched  = 1'b0;
    hit_start    = 0;
    dropped_seen = 1'b0;
  endfunction

  // applies one beat to the search state, returns 1 when a result is due
  function automatic bit advance_search(input op_e op, input logic [7:0] b,
                                        output verdict_t v);
    bit same;
    v = '0;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        drop_text_state();
        return 1'b0;
      end
      OP_APPEND: begin
        if (pat_len < PMAX) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end else begin
          dropped_seen = 1'b1;
        end
        return 1'b0;
      end
      OP_TEXT: begin
        if (text_cnt < TMAX) begin
          for (int unsigned k = PMAX - 1; k > 0; k--) text_win[k] = text_win[k-1];
          text_win[0] = b;
          text_cnt++;
          if (!hit_latched && pat_len > 0 && text_cnt >= pat_len) begin
            same = 1'b1;
            for (int unsigned k = 0; k < pat_len; k++)
              if (text_win[pat_len-1-k] != pat_bytes[k]) same = 1'b0;
            if (same) begin
              hit_latched = 1'b1;
              hit_start   = text_cnt - pat_len;
            end
          end
        end else begin
          dropped_seen = 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (pat_len == 0) begin
          v.found = 1'b1;
          v.pos   = '0;
        end else begin
          v.found = hit_latched;
          v.pos   = hit_latched ? POS_W'(hit_start) : '0;
        end
        v.trunc = dropped_seen;
        drop_text_state();
        return 1'b1;
      end
    endcase
  endfunction

  // offers one beat and returns once it is taken, valid stays high
  task automatic send_beat(input op_e op, input logic [7:0] b, input bit pinned = 1'b0,
                           input verdict_t pinned_v = '0);
    int unsigned gap;
    verdict_t    v;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    beats_sent++;
    if (op == OP_CLEAR) pattern_loads++;
    if (advance_search(op, b, v)) expected_verdicts.push_back(pinned ? pinned_v : v);
  endtask

  // drops valid and waits until every expected result has come out
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_verdicts.size() != 0);
  endtask

  // output ready with random stalls and an on-request long hold-off
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (steady || $urandom_range(0, 99) < 70) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      verdicts_seen++;
      if (m_axis_tdata_o[0]) hits_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: got %h", m_axis_tdata_o);
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata_o[0] !== want.found || m_axis_tdata_o[10:1] !== want.pos ||
            m_axis_tdata_o[11] !== want.trunc || m_axis_tdata_o[15:12] !== 4'h0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d: want found %0b pos %0d trunc %0b, ",
                      "got found %b pos %0d trunc %b pad %h"},
                     verdicts_seen, want.found, want.pos, want.trunc, m_axis_tdata_o[0],
                     m_axis_tdata_o[10:1], m_axis_tdata_o[11], m_axis_tdata_o[15:12]);
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("no completion after %0d cycles", cycle_count);
    $display("substring_first_match_unit_tb: FAIL");
    $finish;
  end

  initial begin
    row_t        rows [24];
    logic [7:0]  cur_pat [$];
    logic [7:0]  b;
    verdict_t    pv;
    int unsigned plen;
    int unsigned tlen;
    int unsigned r;
    int unsigned first_random;

    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = OP_CLEAR;
    steady          = 1'b0;
    long_hold_req   = 1'b0;
    mismatch_count  = 0;
    verdicts_seen   = 0;
    hits_seen       = 0;
    beats_sent      = 0;
    pattern_loads   = 0;
    alpha0          = 8'h61;
    alpha1          = 8'h62;
    for (int unsigned k = 0; k < PMAX; k++) pat_bytes[k] = 8'h00;
    pat_len = 0;
    drop_text_state();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      // empty pattern right after reset
      '{OP_END,    8'h00, 1'b1, 1'b1, 10'd0, 1'b0},
      '{OP_APPEND, 8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_APPEND, 8'h62, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h78, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h62, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_END,    8'h00, 1'b1, 1'b1, 10'd1, 1'b0},
      // pattern longer than text
      '{OP_TEXT,   8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_END,    8'hff, 1'b1, 1'b0, 10'd0, 1'b0},
      // clear, then empty pattern over a text
      '{OP_CLEAR,  8'hff, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h55, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_END,    8'h00, 1'b1, 1'b1, 10'd0, 1'b0},
      '{OP_APPEND, 8'hff, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_APPEND, 8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'hff, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h11, 1'b0, 1'b0, 10'd0, 1'b0},
      // pattern grows mid-text, latched match stays
      '{OP_APPEND, 8'h11, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'hff, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h11, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_END,    8'ha5, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_TEXT,   8'h11, 1'b0, 1'b0, 10'd0, 1'b0},
      '{OP_END,    8'h5a, 1'b0, 1'b0, 10'd0, 1'b0}
    };
    foreach (rows[i])
      send_beat(rows[i].op, rows[i].data, rows[i].pinned,
                '{rows[i].want_found, rows[i].want_pos, rows[i].want_trunc});

    // pattern overflow, then the same pattern again with no drop
    send_beat(OP_CLEAR, 8'h00);
    cur_pat.delete();
    for (int unsigned k = 0; k <= PMAX; k++) begin
      b = 8'($urandom);
      if (k < PMAX) cur_pat.push_back(b);
      send_beat(OP_APPEND, b);
    end
    foreach (cur_pat[k]) send_beat(OP_TEXT, cur_pat[k]);
    send_beat(OP_END, 8'h00);
    send_beat(OP_END, 8'h00);

    // text overflow with the match at the last possible position
    send_beat(OP_CLEAR, 8'h00);
    send_beat(OP_APPEND, 8'hab);
    for (int unsigned k = 0; k < TMAX - 1; k++) send_beat(OP_TEXT, 8'h54);
    send_beat(OP_TEXT, 8'hab);
    send_beat(OP_TEXT, 8'hab);
    pv = '{1'b1, 10'd1023, 1'b1};
    send_beat(OP_END, 8'h00, 1'b1, pv);

    // long output hold-off while end beats keep coming
    drain_results();
    long_hold_req = 1'b1;
    for (int unsigned k = 0; k < 8; k++) begin
      send_beat(OP_TEXT, 8'hab);
      send_beat(OP_END, 8'h00);
    end
    drain_results();

    // random sessions: new pattern now and then, text, end of text
    first_random = beats_sent;
    cur_pat.delete();
    cur_pat.push_back(8'hab);
    while (beats_sent - first_random < RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 10) steady = ~steady;
      if ($urandom_range(0, 99) < 40) begin
        alpha0 = 8'($urandom);
        alpha1 = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70) plen = $urandom_range(1, 4);
        else if (r < 85) plen = 0;
        else if (r < 95) plen = $urandom_range(5, PMAX);
        else plen = $urandom_range(PMAX + 1, PMAX + 2);
        send_beat(OP_CLEAR, 8'($urandom));
        cur_pat.delete();
        for (int unsigned k = 0; k < plen; k++) begin
          b = pick_byte();
          if (cur_pat.size() < PMAX) cur_pat.push_back(b);
          send_beat(OP_APPEND, b);
        end
      end
      tlen = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 24) : $urandom_range(25, 80);
      for (int unsigned k = 0; k < tlen; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6 && cur_pat.size() > 0) begin
          foreach (cur_pat[j]) send_beat(OP_TEXT, cur_pat[j]);
        end else if (r == 6) begin
          b = pick_byte();
          if (cur_pat.size() < PMAX) cur_pat.push_back(b);
          send_beat(OP_APPEND, b);
        end else if (r == 7) begin
          cur_pat.delete();
          send_beat(OP_CLEAR, 8'($urandom));
        end else begin
          send_beat(OP_TEXT, pick_byte());
        end
      end
      send_beat(OP_END, 8'($urandom));
      if ($urandom_range(0, 99) < 5) send_beat(OP_END, 8'($urandom));
      if ($urandom_range(0, 99) < 3) drain_results();
    end

    steady = 1'b0;
    drain_results();
    repeat (20) @(posedge clk_i);

    $display("%0d input beats, %0d pattern loads, %0d results checked (%0d found)",
             beats_sent, pattern_loads, verdicts_seen, hits_seen);
    $display("covered overflow of pattern and text, output hold-off, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("substring_first_match_unit_tb: PASS");
    end else begin
      $display("%0d results still expected", expected_verdicts.size());
      $display("substring_first_match_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sfm_pkg.sv
src/sfm_match_core.sv
src/substring_first_match_unit.sv
test/substring_first_match_unit_tb.sv
